@@ rtl/ntc_pkg.sv @@
// Shared constants, types and the logarithm table for the NTC thermistor temperature core.
package ntc_pkg;

  localparam int LOG_TABLE_ENTRIES = 64;
  localparam int FRACTION_BITS     = 16;
  localparam int LOG_IDX_W         = $clog2(LOG_TABLE_ENTRIES);

  localparam int SAMPLE_W   = 13;
  localparam int SERIES_W   = 20;
  localparam int NOMRES_W   = 20;
  localparam int NOMTEMP_W  = 9;
  localparam int BETA_W     = 14;
  localparam int SUPPLY_W   = 13;
  localparam int RES_W      = 24;
  localparam int TEMP_W     = 16;
  localparam int STATUS_W   = 2;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  localparam int MANT_W  = 20;
  localparam int EXP_W   = $clog2(RES_W);
  localparam int LN_W    = FRACTION_BITS + 5;
  localparam int LDIFF_W = LN_W + 1;
  localparam int LN_LAT  = 4;

  localparam int RNUM_W  = SERIES_W + SAMPLE_W;
  localparam int RCMP_W  = SUPPLY_W + RES_W;

  localparam int T0C_W   = 16;
  localparam int T0F_W   = 18;
  localparam int B100_W  = 21;
  localparam int BNUM_W  = B100_W + T0C_W;
  localparam int BQ_W    = B100_W + FRACTION_BITS;
  localparam int DEN_W   = BQ_W + 2;
  localparam int PROD_W  = DEN_W;
  localparam int TNUM_W  = BNUM_W + FRACTION_BITS + 1;
  localparam int TK_W    = 16;
  localparam int TCMP_W  = TNUM_W + 1;

  localparam int PIPE_DEPTH = RES_W + TK_W + LN_LAT + 9;

  localparam int KELVIN_CENTI = 27315;
  localparam logic [RES_W-1:0]         R_MAX     = '1;
  localparam logic signed [TEMP_W-1:0] TEMP_LOW  = -16'sd5500;
  localparam logic signed [TEMP_W-1:0] TEMP_HIGH = 16'sd25000;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_SERIES  = 3'd0,
    REG_NOMRES  = 3'd1,
    REG_NOMTEMP = 3'd2,
    REG_BETA    = 3'd3,
    REG_SUPPLY  = 3'd4
  } reg_idx_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK          = 2'd0,
    STATUS_OVER_SUPPLY = 2'd1,
    STATUS_ZERO_VOLT   = 2'd2,
    STATUS_CLAMPED     = 2'd3
  } status_t;

  typedef struct packed {
    logic                over;
    logic                zero;
    logic                sat;
    logic [RNUM_W-1:0]   rem;
    logic [SUPPLY_W-1:0] den;
    logic [RES_W-1:0]    q;
  } rdiv_t;

  typedef struct packed {
    logic             over;
    logic             zero;
    logic [RES_W-1:0] res;
  } side_t;

  typedef struct packed {
    side_t              side;
    logic               dpos;
    logic               sat;
    logic [TNUM_W-1:0]  rem;
    logic [DEN_W-2:0]   den;
    logic [TK_W-1:0]    q;
  } tdiv_t;

  typedef struct packed {
    logic [RES_W-1:0]         res;
    logic signed [TEMP_W-1:0] temp;
    status_t                  status;
  } result_t;

  typedef longint unsigned u64_t;
  typedef logic [FRACTION_BITS-1:0] log_rom_t [0:LOG_TABLE_ENTRIES];

  // Shift-and-subtract quotient, used only while the table is built.
  function automatic u64_t div_u64(u64_t num, u64_t den);
    u64_t quo;
    u64_t rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Samples of ln(1 + k/N) from the series 2*atanh(k/(2N+k)), rounded half up.
  function automatic log_rom_t build_log_rom();
    log_rom_t rom;
    u64_t     z;
    u64_t     z2;
    u64_t     term;
    u64_t     sum;
    u64_t     ln30;
    for (int k = 0; k <= LOG_TABLE_ENTRIES; k++) begin
      z    = div_u64(u64_t'(k) << 30, u64_t'(2 * LOG_TABLE_ENTRIES + k));
      z2   = (z * z) >> 30;
      term = z;
      sum  = 0;
      for (int n = 1; n <= 61; n += 2) begin
        sum  = sum + div_u64(term, u64_t'(n));
        term = (term * z2) >> 30;
      end
      ln30   = 2 * sum;
      rom[k] = FRACTION_BITS'((ln30 + (u64_t'(1) << (29 - FRACTION_BITS)))
                              >> (30 - FRACTION_BITS));
    end
    return rom;
  endfunction

  localparam log_rom_t LOG_ROM = build_log_rom();

endpackage

@@ rtl/ntc_in_if.sv @@
// Sample channel carrying one divider voltage word.
interface ntc_in_if;
  import ntc_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample_millivolts;

  modport source (output valid, output sample_millivolts, input ready);
  modport sink   (input valid, input sample_millivolts, output ready);
endinterface

@@ rtl/ntc_out_if.sv @@
// Result channel carrying resistance, temperature and status.
interface ntc_out_if;
  import ntc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [RES_W-1:0]         resistance_ohms;
  logic signed [TEMP_W-1:0] temperature_centi_c;
  logic [STATUS_W-1:0]      status;

  modport source (output valid, output resistance_ohms, output temperature_centi_c,
                  output status, input ready);
  modport sink   (input valid, input resistance_ohms, input temperature_centi_c,
                  input status, output ready);
endinterface

@@ rtl/ntc_ln.sv @@
// Four-stage pipelined natural logarithm by table lookup with linear interpolation.
module ntc_ln (
  input  logic                     clk,
  input  logic                     en,
  input  logic [ntc_pkg::RES_W-1:0] x,
  output logic [ntc_pkg::LN_W-1:0]  ln_q
);
  import ntc_pkg::*;

  logic [EXP_W-1:0]                lead_e;
  logic [RES_W-1:0]                x_norm;
  logic [LOG_IDX_W-1:0]            idx;
  logic [LOG_IDX_W:0]              idx_hi;
  logic [FRACTION_BITS+MANT_W-1:0] interp_full;

  logic [EXP_W-1:0]         e_a_r;
  logic [MANT_W-1:0]        t_a_r;
  logic [EXP_W-1:0]         e_b_r;
  logic [FRACTION_BITS-1:0] lo_b_r;
  logic [FRACTION_BITS-1:0] diff_b_r;
  logic [MANT_W-1:0]        fr_b_r;
  logic [FRACTION_BITS-1:0] lo_c_r;
  logic [FRACTION_BITS-1:0] interp_c_r;
  logic [LN_W-1:0]          elog_c_r;
  logic [LN_W-1:0]          ln_r;

  always_comb begin
    lead_e = '0;
    for (int i = 1; i < RES_W; i++) begin
      if (x[i]) begin
        lead_e = EXP_W'(i);
      end
    end
  end

  assign x_norm      = x << (EXP_W'(RES_W - 1) - lead_e);
  assign idx         = t_a_r[MANT_W-1 -: LOG_IDX_W];
  assign idx_hi      = {1'b0, idx} + 1'b1;
  assign interp_full = diff_b_r * fr_b_r;

  always_ff @(posedge clk) begin
    if (en) begin
      e_a_r      <= lead_e;
      t_a_r      <= x_norm[RES_W-2 -: MANT_W];
      e_b_r      <= e_a_r;
      lo_b_r     <= LOG_ROM[idx];
      diff_b_r   <= LOG_ROM[idx_hi] - LOG_ROM[idx];
      fr_b_r     <= {t_a_r[MANT_W-LOG_IDX_W-1:0], {LOG_IDX_W{1'b0}}};
      lo_c_r     <= lo_b_r;
      interp_c_r <= interp_full[MANT_W +: FRACTION_BITS];
      elog_c_r   <= LN_W'(e_b_r) * LN_W'(LOG_ROM[LOG_TABLE_ENTRIES]);
      ln_r       <= elog_c_r + LN_W'(lo_c_r) + LN_W'(interp_c_r);
    end
  end

  assign ln_q = ln_r;

endmodule

@@ rtl/ntc_thermistor_temperature_core.sv @@
// Throughput: one word per cycle while the skid register is empty; two restoring dividers
// of one quotient bit per stage (24 for the resistance, 16 for the temperature) set the
// pipeline depth.
// A stalled result parks in a skid register and the pipeline freezes only while it is full.
// Reset is synchronous and active low; it empties the pipeline and loads the register defaults.
// The logarithm table is a constant, so no clearing pass follows reset.
module ntc_thermistor_temperature_core (
  input  logic                          clk,
  input  logic                          rst_n,
  ntc_in_if.sink                        in_ch,
  ntc_out_if.source                     out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ntc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [ntc_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [ntc_pkg::CFG_DATA_W-1:0] prdata,
  output logic                          pready
);
  import ntc_pkg::*;

  logic [SERIES_W-1:0]  series_r;
  logic [NOMRES_W-1:0]  nomres_r;
  logic [NOMTEMP_W-1:0] nomtemp_r;
  logic [BETA_W-1:0]    beta_r;
  logic [SUPPLY_W-1:0]  supply_r;
  reg_idx_t             cfg_idx;
  logic                 cfg_wr;

  logic [NOMRES_W-1:0]    r0;
  logic signed [T0F_W-1:0] t0c_full;
  logic [T0C_W-1:0]       t0c_r;
  logic signed [T0C_W:0]  t0c_s;
  logic [B100_W-1:0]      b100_r;
  logic [BNUM_W-1:0]      bnum_r;
  logic [BQ_W-1:0]        bq;
  logic [LN_W-1:0]        ln_res;
  logic [LN_W-1:0]        ln_nom;

  logic                   en;
  logic [PIPE_DEPTH-1:0]  vld_r;
  rdiv_t                  s1_r;
  rdiv_t                  rdv0_nxt;
  rdiv_t                  rdv_r [0:RES_W];
  side_t                  s3_r;
  side_t                  lnd_r [1:LN_LAT];
  side_t                  s4_side_r;
  logic signed [LDIFF_W-1:0] s4_l_r;
  side_t                  s5_side_r;
  logic signed [PROD_W-1:0]  s5_prod_r;
  side_t                  s6_side_r;
  logic signed [DEN_W-1:0]   s6_den_r;
  tdiv_t                  s7_r;
  tdiv_t                  tdv0_nxt;
  tdiv_t                  tdv_r [0:TK_W];
  logic signed [TK_W:0]   temp_raw;
  result_t                fin_nxt;
  result_t                fin_r;

  logic    out_vld_r;
  logic    out_vld_nxt;
  logic    skid_vld_r;
  logic    skid_vld_nxt;
  result_t out_r;
  result_t skid_r;
  logic    load_from_skid;
  logic    load_from_pipe;
  logic    load_skid;

  // Configuration registers.
  assign cfg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      series_r  <= SERIES_W'(10000);
      nomres_r  <= NOMRES_W'(10000);
      nomtemp_r <= NOMTEMP_W'(25);
      beta_r    <= BETA_W'(3950);
      supply_r  <= SUPPLY_W'(3300);
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SERIES:  series_r  <= pwdata[SERIES_W-1:0];
        REG_NOMRES:  nomres_r  <= pwdata[NOMRES_W-1:0];
        REG_NOMTEMP: nomtemp_r <= pwdata[NOMTEMP_W-1:0];
        REG_BETA:    beta_r    <= pwdata[BETA_W-1:0];
        REG_SUPPLY:  supply_r  <= pwdata[SUPPLY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (cfg_idx)
      REG_SERIES:  prdata = CFG_DATA_W'(series_r);
      REG_NOMRES:  prdata = CFG_DATA_W'(nomres_r);
      REG_NOMTEMP: prdata = CFG_DATA_W'(nomtemp_r);
      REG_BETA:    prdata = CFG_DATA_W'(beta_r);
      REG_SUPPLY:  prdata = CFG_DATA_W'(supply_r);
      default:     prdata = '0;
    endcase
  end

  // Terms that depend on the registers alone are registered (t0c_r, b100_r, then bnum_r; ln_nom via u_ln_nom).
  assign r0       = (nomres_r == '0) ? NOMRES_W'(1) : nomres_r;
  assign t0c_full = T0F_W'($signed(nomtemp_r)) * T0F_W'(100) + T0F_W'(KELVIN_CENTI);
  assign t0c_s    = $signed({1'b0, t0c_r});
  assign bq       = {b100_r, {FRACTION_BITS{1'b0}}};

  always_ff @(posedge clk) begin
    t0c_r  <= t0c_full[T0C_W-1:0];
    b100_r <= B100_W'(beta_r) * B100_W'(100);
    bnum_r <= BNUM_W'(b100_r) * BNUM_W'(t0c_r);
  end

  ntc_ln u_ln_nom (
    .clk  (clk),
    .en   (1'b1),
    .x    (RES_W'(r0)),
    .ln_q (ln_nom)
  );

  // Pipeline valid bits.
  assign en          = !skid_vld_r;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_DEPTH-2:0], in_ch.valid};
    end
  end

  // Resistance: product, then one quotient bit per stage.
  always_comb begin
    rdv0_nxt     = s1_r;
    rdv0_nxt.sat = RCMP_W'(s1_r.rem) >= (RCMP_W'(s1_r.den) << RES_W);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r.over <= in_ch.sample_millivolts >= supply_r;
      s1_r.zero <= in_ch.sample_millivolts == '0;
      s1_r.sat  <= 1'b0;
      s1_r.rem  <= RNUM_W'(series_r) * RNUM_W'(in_ch.sample_millivolts);
      s1_r.den  <= supply_r - in_ch.sample_millivolts;
      s1_r.q    <= '0;
      rdv_r[0]  <= rdv0_nxt;
    end
  end

  for (genvar k = 0; k < RES_W; k++) begin : g_rdiv
    localparam int BIT = RES_W - 1 - k;
    logic [RCMP_W-1:0] trial;
    logic              take;
    rdiv_t             stage_nxt;

    assign trial = RCMP_W'(rdv_r[k].den) << BIT;
    assign take  = RCMP_W'(rdv_r[k].rem) >= trial;

    always_comb begin
      stage_nxt = rdv_r[k];
      if (take) begin
        stage_nxt.rem    = RNUM_W'(RCMP_W'(rdv_r[k].rem) - trial);
        stage_nxt.q[BIT] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rdv_r[k+1] <= stage_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_r.over <= rdv_r[RES_W].over;
      s3_r.zero <= rdv_r[RES_W].zero;
      if (rdv_r[RES_W].over || rdv_r[RES_W].sat) begin
        s3_r.res <= R_MAX;
      end else if (rdv_r[RES_W].zero) begin
        s3_r.res <= '0;
      end else begin
        s3_r.res <= rdv_r[RES_W].q;
      end
    end
  end

  // Logarithm of the resistance, with the side information delayed alongside.
  ntc_ln u_ln_res (
    .clk  (clk),
    .en   (en),
    .x    (s3_r.res),
    .ln_q (ln_res)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      lnd_r[1] <= s3_r;
      for (int i = 2; i <= LN_LAT; i++) begin
        lnd_r[i] <= lnd_r[i-1];
      end
    end
  end

  // Beta equation denominator and numerator.
  always_comb begin
    tdv0_nxt     = s7_r;
    tdv0_nxt.sat = TCMP_W'(s7_r.rem) >= (TCMP_W'(s7_r.den) << TK_W);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_side_r <= lnd_r[LN_LAT];
      s4_l_r    <= $signed({1'b0, ln_res}) - $signed({1'b0, ln_nom});
      s5_side_r <= s4_side_r;
      s5_prod_r <= s4_l_r * t0c_s;
      s6_side_r <= s5_side_r;
      s6_den_r  <= $signed(DEN_W'(bq)) + s5_prod_r;
      s7_r.side <= s6_side_r;
      s7_r.dpos <= !s6_den_r[DEN_W-1] && (s6_den_r != '0);
      s7_r.sat  <= 1'b0;
      s7_r.rem  <= TNUM_W'({bnum_r, {FRACTION_BITS{1'b0}}}) + TNUM_W'(s6_den_r[DEN_W-2:1]);
      s7_r.den  <= s6_den_r[DEN_W-2:0];
      s7_r.q    <= '0;
      tdv_r[0]  <= tdv0_nxt;
    end
  end

  for (genvar k = 0; k < TK_W; k++) begin : g_tdiv
    localparam int BIT = TK_W - 1 - k;
    logic [TCMP_W-1:0] trial;
    logic              take;
    tdiv_t             stage_nxt;

    assign trial = TCMP_W'(tdv_r[k].den) << BIT;
    assign take  = TCMP_W'(tdv_r[k].rem) >= trial;

    always_comb begin
      stage_nxt = tdv_r[k];
      if (take) begin
        stage_nxt.rem    = TNUM_W'(TCMP_W'(tdv_r[k].rem) - trial);
        stage_nxt.q[BIT] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tdv_r[k+1] <= stage_nxt;
      end
    end
  end

  // Special cases and clamping.
  assign temp_raw = $signed({1'b0, tdv_r[TK_W].q}) - $signed((TK_W+1)'(KELVIN_CENTI));

  always_comb begin
    fin_nxt.res = tdv_r[TK_W].side.res;
    if (tdv_r[TK_W].side.over) begin
      fin_nxt.temp   = TEMP_LOW;
      fin_nxt.status = STATUS_OVER_SUPPLY;
    end else if (tdv_r[TK_W].side.zero) begin
      fin_nxt.temp   = TEMP_HIGH;
      fin_nxt.status = STATUS_ZERO_VOLT;
    end else if ((tdv_r[TK_W].side.res == '0) || !tdv_r[TK_W].dpos || tdv_r[TK_W].sat) begin
      fin_nxt.temp   = TEMP_HIGH;
      fin_nxt.status = STATUS_CLAMPED;
    end else if (temp_raw < TEMP_LOW) begin
      fin_nxt.temp   = TEMP_LOW;
      fin_nxt.status = STATUS_CLAMPED;
    end else if (temp_raw > TEMP_HIGH) begin
      fin_nxt.temp   = TEMP_HIGH;
      fin_nxt.status = STATUS_CLAMPED;
    end else begin
      fin_nxt.temp   = TEMP_W'(temp_raw);
      fin_nxt.status = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_r <= fin_nxt;
    end
  end

  // Output register with a skid register behind it.
  assign load_from_skid = skid_vld_r && out_ch.ready;
  assign load_from_pipe = !skid_vld_r && (!out_vld_r || out_ch.ready);
  assign load_skid      = !skid_vld_r && out_vld_r && !out_ch.ready && vld_r[PIPE_DEPTH-1];

  always_comb begin
    out_vld_nxt  = out_vld_r;
    skid_vld_nxt = skid_vld_r;
    if (load_from_skid) begin
      out_vld_nxt  = 1'b1;
      skid_vld_nxt = 1'b0;
    end else if (load_from_pipe) begin
      out_vld_nxt = vld_r[PIPE_DEPTH-1];
    end else if (load_skid) begin
      skid_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_from_skid) begin
      out_r <= skid_r;
    end else if (load_from_pipe) begin
      out_r <= fin_r;
    end
    if (load_skid) begin
      skid_r <= fin_r;
    end
  end

  assign out_ch.valid               = out_vld_r;
  assign out_ch.resistance_ohms     = out_r.res;
  assign out_ch.temperature_centi_c = out_r.temp;
  assign out_ch.status              = out_r.status;

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid word held without an output word");

  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_vld_r) |-> $past(out_vld_r && !out_ch.ready))
    else $error("skid register filled without an output stall");

  a_over_supply_res: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (out_r.status == STATUS_OVER_SUPPLY)) |-> (out_r.res == R_MAX))
    else $error("over-supply word without saturated resistance");

  a_ok_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (out_r.status == STATUS_OK)) |->
      ((out_r.temp >= TEMP_LOW) && (out_r.temp <= TEMP_HIGH)))
    else $error("unclamped temperature outside range");
`endif

endmodule
